// File: rtl/core/stdt_pkg.sv
// ----------------------------------------------------------------------------
// stdt_pkg
// Shared types, codes and helpers for the stalled task detector table.
// ----------------------------------------------------------------------------
package stdt_pkg;

	localparam int NAME_BYTES = 16;
	localparam int NAME_W     = 8 * NAME_BYTES;
	localparam int CNT_W      = 32;
	localparam int BUDGET_W   = 16;
	localparam int STATUS_W   = 3;
	localparam int CFG_IDX_W  = 8;

	localparam logic [BUDGET_W-1:0] DEFAULT_WARNINGS = 16'd10;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_WARNING_LIMIT = 8'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PANIC_ENABLE  = 8'd1;

	typedef enum logic [1:0] {
		CMD_CLEAR = 2'd0,
		CMD_WRITE = 2'd1,
		CMD_CHECK = 2'd2
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		STAT_DONE        = 3'd0,
		STAT_EXCLUDED    = 3'd1,
		STAT_SKIPPED     = 3'd2,
		STAT_PROGRESS    = 3'd3,
		STAT_HUNG        = 3'd4,
		STAT_HUNG_SILENT = 3'd5,
		STAT_FULL        = 3'd6
	} stat_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXCL,
		S_TRK,
		S_FINISH
	} state_t;

	// byte k is kept when bytes 0..k are all nonzero (name ends at first zero)
	function automatic logic [NAME_BYTES-1:0] name_keep(input logic [NAME_W-1:0] name);
		logic [NAME_BYTES-1:0] keep;
		logic                  run;
		run = 1'b1;
		for (int k = 0; k < NAME_BYTES; k++) begin
			run     = run & (name[8*k +: 8] != 8'h00);
			keep[k] = run;
		end
		return keep;
	endfunction

	// widen a byte keep vector into a bit mask
	function automatic logic [NAME_W-1:0] byte_mask(input logic [NAME_BYTES-1:0] keep);
		logic [NAME_W-1:0] m;
		for (int k = 0; k < NAME_BYTES; k++) begin
			m[8*k +: 8] = {8{keep[k]}};
		end
		return m;
	endfunction

endpackage

// File: rtl/core/stdt_ram.sv
// ----------------------------------------------------------------------------
// stdt_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module stdt_ram #(
	parameter int WIDTH = 128,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// File: rtl/core/stdt_cmp.sv
// ----------------------------------------------------------------------------
// stdt_cmp
// Shared compare unit: byte-masked name match and switch count match.
// ----------------------------------------------------------------------------
module stdt_cmp
	import stdt_pkg::*;
(
	input  logic [NAME_W-1:0]     stored_name,
	input  logic [NAME_W-1:0]     key_name,
	input  logic [NAME_BYTES-1:0] byte_en,
	input  logic [CNT_W-1:0]      stored_count,
	input  logic [CNT_W-1:0]      key_count,
	output logic                  name_eq,
	output logic                  count_eq
);

	// only enabled bytes take part in the name match
	assign name_eq  = ((stored_name ^ key_name) & byte_mask(byte_en)) == '0;
	assign count_eq = stored_count == key_count;

endmodule

// File: rtl/core/stalled_task_detector_table.sv
// Commands 0, 1 and 3 go from idle to the finish state, which loads the result into
// the output register once it is free. A check walks the exclusion list and, if
// needed, the tracked table, one entry per cycle through the shared compare unit.
// Throughput: one item at a time; the input is not ready until the result is queued.
// Reset (arst_n low, asynchronous): both lists empty, budget 10, panic enabled.
// RAM contents are not cleared; per-entry valid bits mark what is in use.
// ----------------------------------------------------------------------------
// stalled_task_detector_table
// Tracks task names and switch counts, flags tasks whose count stops moving.
// ----------------------------------------------------------------------------
module stalled_task_detector_table
	import stdt_pkg::*;
#(
	parameter int TABLE_ENTRIES = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// input items
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	// slot[3:0], name_lo[67:4], name_hi[131:68], frozen[132],
	// switches[164:133], zero pad[167:165]
	input  logic [167:0]         s_axis_tdata,
	// cmd[1:0]
	input  logic [1:0]           s_axis_tuser,
	// result items
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	// status[2:0], panic[3], warnings_remaining[19:4], zero pad[23:20]
	output logic [23:0]          m_axis_tdata,
	// configuration writes
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [BUDGET_W-1:0]  cfg_data
);

	localparam int IDX_W     = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int CNT_IDX_W = $clog2(TABLE_ENTRIES + 1);
	localparam logic [CNT_IDX_W-1:0] SCAN_END = CNT_IDX_W'(TABLE_ENTRIES);
	localparam logic [IDX_W-1:0]     LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);
	localparam int TRK_W = CNT_W + NAME_W;

	// input unpack
	logic                  in_acc;
	logic [3:0]            in_slot;
	logic [NAME_W-1:0]     in_name;
	logic                  in_frozen;
	logic [CNT_W-1:0]      in_count;
	cmd_t                  in_cmd;
	logic [NAME_BYTES-1:0] in_keep;
	logic [NAME_W-1:0]     in_trim;
	logic                  slot_ok;

	assign in_slot   = s_axis_tdata[3:0];
	assign in_name   = s_axis_tdata[131:4];
	assign in_frozen = s_axis_tdata[132];
	assign in_count  = s_axis_tdata[164:133];
	assign in_cmd    = cmd_t'(s_axis_tuser);
	assign in_acc    = s_axis_tvalid && s_axis_tready;
	assign in_keep   = name_keep(in_name);
	assign in_trim   = in_name & byte_mask(in_keep);
	assign slot_ok   = 32'(in_slot) < TABLE_ENTRIES;

	// control state
	state_t                 state_q, state_d;
	logic [CNT_IDX_W-1:0]   cnt_q;
	logic [IDX_W-1:0]       idx_s1;
	logic                   live_s1;
	logic                   empty_found_q;
	logic [IDX_W-1:0]       empty_idx_q;
	logic [TABLE_ENTRIES-1:0] excl_vld_q;
	logic [TABLE_ENTRIES-1:0] trk_vld_q;
	logic [BUDGET_W-1:0]    budget_q;
	logic                   panic_en_q;
	logic                   m_valid_q;

	// item payload
	logic [NAME_W-1:0]     name_q;
	logic [NAME_BYTES-1:0] keep_q;
	logic [CNT_W-1:0]      count_q;
	logic                  frozen_q;
	stat_t                 status_q;
	logic                  panic_q;
	logic [23:0]           m_data_q;

	// sequencer decisions
	logic                  scan_rst;
	logic                  res_load;
	stat_t                 res_status;
	logic                  res_panic;
	logic                  budget_dec;
	logic                  trk_we;
	logic [IDX_W-1:0]      trk_waddr;
	logic                  excl_we;
	logic                  excl_clr;
	logic                  empty_set;
	logic                  out_load;

	// memories and compare unit
	logic [NAME_W-1:0]     excl_rdata;
	logic [TRK_W-1:0]      trk_rdata;
	logic [NAME_W-1:0]     cmp_stored;
	logic [NAME_BYTES-1:0] cmp_en;
	logic                  name_eq;
	logic                  cnt_eq;

	assign s_axis_tready = (state_q == S_IDLE);
	assign cfg_ready     = 1'b1;
	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;
	assign out_load      = (state_q == S_FINISH) && (!m_valid_q || m_axis_tready);

	stdt_ram #(
		.WIDTH (NAME_W),
		.DEPTH (TABLE_ENTRIES)
	) u_excl_ram (
		.clk   (clk),
		.we    (excl_we),
		.waddr (IDX_W'(in_slot)),
		.wdata (in_trim),
		.raddr (cnt_q[IDX_W-1:0]),
		.rdata (excl_rdata)
	);

	stdt_ram #(
		.WIDTH (TRK_W),
		.DEPTH (TABLE_ENTRIES)
	) u_trk_ram (
		.clk   (clk),
		.we    (trk_we),
		.waddr (trk_waddr),
		.wdata ({count_q, name_q}),
		.raddr (cnt_q[IDX_W-1:0]),
		.rdata (trk_rdata)
	);

	// exclusion scan matches on the name prefix, table scan on the whole name
	assign cmp_stored = (state_q == S_EXCL) ? excl_rdata : trk_rdata[NAME_W-1:0];
	assign cmp_en     = (state_q == S_EXCL) ? keep_q : '1;

	stdt_cmp u_cmp (
		.stored_name  (cmp_stored),
		.key_name     (name_q),
		.byte_en      (cmp_en),
		.stored_count (trk_rdata[TRK_W-1:NAME_W]),
		.key_count    (count_q),
		.name_eq      (name_eq),
		.count_eq     (cnt_eq)
	);

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and decisions
	always_comb begin
		state_d    = state_q;
		scan_rst   = 1'b0;
		res_load   = 1'b0;
		res_status = STAT_DONE;
		res_panic  = 1'b0;
		budget_dec = 1'b0;
		trk_we     = 1'b0;
		trk_waddr  = idx_s1;
		excl_we    = 1'b0;
		excl_clr   = 1'b0;
		empty_set  = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (in_acc) begin
					scan_rst = 1'b1;
					case (in_cmd)
						CMD_CLEAR: begin
							excl_clr = 1'b1;
							res_load = 1'b1;
							state_d  = S_FINISH;
						end
						CMD_WRITE: begin
							excl_we  = slot_ok;
							res_load = 1'b1;
							state_d  = S_FINISH;
						end
						CMD_CHECK: begin
							state_d = S_EXCL;
						end
						default: begin
							res_load = 1'b1;
							state_d  = S_FINISH;
						end
					endcase
				end
			end
			S_EXCL: begin
				if (live_s1) begin
					if (excl_vld_q[idx_s1] && name_eq) begin
						res_load   = 1'b1;
						res_status = STAT_EXCLUDED;
						state_d    = S_FINISH;
					end else if (!excl_vld_q[idx_s1] || idx_s1 == LAST_IDX) begin
						// list exhausted without a match
						if (frozen_q || count_q == '0) begin
							res_load   = 1'b1;
							res_status = STAT_SKIPPED;
							state_d    = S_FINISH;
						end else begin
							scan_rst = 1'b1;
							state_d  = S_TRK;
						end
					end
				end
			end
			S_TRK: begin
				if (live_s1) begin
					if (trk_vld_q[idx_s1] && name_eq) begin
						res_load = 1'b1;
						state_d  = S_FINISH;
						if (!cnt_eq) begin
							trk_we     = 1'b1;
							res_status = STAT_PROGRESS;
						end else if (budget_q == '0) begin
							res_status = STAT_HUNG_SILENT;
						end else begin
							budget_dec = 1'b1;
							res_status = STAT_HUNG;
							res_panic  = panic_en_q;
						end
					end else if (idx_s1 == LAST_IDX) begin
						// new name: first empty slot, or the table is full
						res_load = 1'b1;
						state_d  = S_FINISH;
						if (empty_found_q) begin
							trk_we     = 1'b1;
							trk_waddr  = empty_idx_q;
							res_status = STAT_PROGRESS;
						end else if (!trk_vld_q[idx_s1]) begin
							trk_we     = 1'b1;
							res_status = STAT_PROGRESS;
						end else begin
							res_status = STAT_FULL;
						end
					end else if (!trk_vld_q[idx_s1] && !empty_found_q) begin
						empty_set = 1'b1;
					end
				end
			end
			S_FINISH: begin
				if (!m_valid_q || m_axis_tready) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// scan counter, read stage and control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q         <= '0;
			idx_s1        <= '0;
			live_s1       <= 1'b0;
			empty_found_q <= 1'b0;
			empty_idx_q   <= '0;
			excl_vld_q    <= '0;
			trk_vld_q     <= '0;
			budget_q      <= DEFAULT_WARNINGS;
			panic_en_q    <= 1'b1;
			m_valid_q     <= 1'b0;
		end else begin
			if (scan_rst) begin
				cnt_q         <= '0;
				live_s1       <= 1'b0;
				empty_found_q <= 1'b0;
			end else if (state_q == S_EXCL || state_q == S_TRK) begin
				cnt_q   <= (cnt_q == SCAN_END) ? cnt_q : cnt_q + 1'b1;
				live_s1 <= (cnt_q != SCAN_END);
				idx_s1  <= cnt_q[IDX_W-1:0];
				if (empty_set) begin
					empty_found_q <= 1'b1;
					empty_idx_q   <= idx_s1;
				end
			end

			// valid bit follows "stored name is nonzero"
			if (excl_clr) begin
				excl_vld_q <= '0;
			end else if (excl_we) begin
				excl_vld_q[IDX_W'(in_slot)] <= in_keep[0];
			end
			if (trk_we) begin
				trk_vld_q[trk_waddr] <= keep_q[0];
			end

			// budget: a limit write reloads it
			if (cfg_valid && cfg_ready && cfg_index == CFG_WARNING_LIMIT) begin
				budget_q <= cfg_data;
			end else if (budget_dec) begin
				budget_q <= budget_q - 1'b1;
			end
			if (cfg_valid && cfg_ready && cfg_index == CFG_PANIC_ENABLE) begin
				panic_en_q <= cfg_data[0];
			end

			// output register
			if (out_load) begin
				m_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	// item payload and result registers
	always_ff @(posedge clk) begin
		if (in_acc) begin
			name_q   <= in_trim;
			keep_q   <= in_keep;
			count_q  <= in_count;
			frozen_q <= in_frozen;
		end
		if (res_load) begin
			status_q <= res_status;
			panic_q  <= res_panic;
		end
		if (out_load) begin
			m_data_q <= {4'b0000, budget_q, panic_q, status_q};
		end
	end

endmodule

// File: rtl/core/stdt_chk.sv
// ----------------------------------------------------------------------------
// stdt_chk
// Port-level checks for the stalled task detector table, bound to the top.
// ----------------------------------------------------------------------------
module stdt_chk
	import stdt_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [23:0] m_axis_tdata
);

	// a held result item keeps its contents
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result item changed while stalled");

	// one item at a time: busy right after an accept
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("input taken while an item is in work");

	// panic only comes with a hung report
	a_panic: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[3] |-> m_axis_tdata[2:0] == STAT_HUNG)
		else $error("panic without a hung report");

	// silent hung only once the budget is used up
	a_silent: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[2:0] == STAT_HUNG_SILENT |-> m_axis_tdata[19:4] == '0)
		else $error("silent hung with budget left");

endmodule

bind stalled_task_detector_table stdt_chk u_stdt_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);

// File: bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for stalled_task_detector_table. Check, exclusion and
// clear items go in on the input stream. A predictor works out the status,
// panic flag and remaining warning budget of every item. Each result on the
// output stream is compared with the oldest prediction. Random idles on both
// sides, a long output hold-off and several register settings are included.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import stdt_pkg::*;

	localparam int         ENTRIES      = 16;
	localparam int         POOL         = 20;
	localparam int         BASE_POOL    = 14;
	localparam int         STALL_LIMIT  = 3000;
	localparam int         HOLD_CYCLES  = 200;
	localparam int         DRAIN_CYCLES = 40;
	localparam logic [1:0] CMD_SPARE    = 2'd3;

	typedef struct {
		logic [1:0]   cmd;
		logic [3:0]   slot;
		logic [127:0] name;
		logic         frozen;
		logic [31:0]  switches;
	} probe_t;

	typedef struct {
		stat_t       status;
		logic        panic;
		logic [15:0] warnings;
	} verdict_t;

	logic                 clk;
	logic                 arst_n;
	logic                 s_axis_tvalid;
	logic                 s_axis_tready;
	logic [167:0]         s_axis_tdata;
	logic [1:0]           s_axis_tuser;
	logic                 m_axis_tvalid;
	logic                 m_axis_tready;
	logic [23:0]          m_axis_tdata;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [BUDGET_W-1:0]  cfg_data;

	// predicted block state
	logic [127:0] excl_name [ENTRIES];
	logic [127:0] trk_name  [ENTRIES];
	logic [31:0]  trk_count [ENTRIES];
	logic [15:0]  budget_left;
	logic         panic_on;
	verdict_t     expected_verdicts [$];

	// task names used by the random part, with the last nonzero count sent for each
	logic [127:0] pool_name  [POOL];
	int           pool_len   [POOL];
	logic [31:0]  pool_count [POOL];
	int           active_pool;

	bit calm;
	bit hold_req;
	int fault_count;
	int sent_count;
	int cfg_count;
	int status_seen [8];

	stalled_task_detector_table u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// next state and result of one item; trims the name at its first zero byte
	function automatic verdict_t judge_item(input probe_t p);
		logic [127:0] name;
		logic [127:0] keep;
		int           len;
		int           hit;
		int           hole;
		bit           excluded;
		bit           stop;
		verdict_t     v;
		len = 16;
		for (int k = 15; k >= 0; k--)
			if (p.name[8*k +: 8] == 8'h00) len = k;
		keep = '0;
		for (int k = 0; k < 16; k++)
			if (k < len) keep[8*k +: 8] = 8'hFF;
		name = p.name & keep;
		v.status = STAT_DONE;
		v.panic  = 1'b0;
		case (p.cmd)
			CMD_CLEAR: begin
				for (int i = 0; i < ENTRIES; i++) excl_name[i] = '0;
			end
			CMD_WRITE: begin
				excl_name[p.slot] = name;
			end
			CMD_CHECK: begin
				// prefix match over the list, up to its first empty slot
				excluded = 1'b0;
				stop     = 1'b0;
				for (int i = 0; i < ENTRIES; i++) begin
					if (!stop) begin
						if (excl_name[i] == '0) begin
							stop = 1'b1;
						end else if (((excl_name[i] ^ name) & keep) == '0) begin
							excluded = 1'b1;
							stop     = 1'b1;
						end
					end
				end
				if (excluded) begin
					v.status = STAT_EXCLUDED;
				end else if (p.frozen || p.switches == 0) begin
					v.status = STAT_SKIPPED;
				end else begin
					hit  = -1;
					hole = -1;
					for (int i = 0; i < ENTRIES; i++) begin
						if (hit < 0) begin
							if (trk_name[i] == '0) begin
								if (hole < 0) hole = i;
							end else if (trk_name[i] == name) begin
								hit = i;
							end
						end
					end
					if (hit < 0) begin
						if (hole < 0) begin
							v.status = STAT_FULL;
						end else begin
							// an empty name lands here too and leaves the slot empty
							trk_name[hole]  = name;
							trk_count[hole] = p.switches;
							v.status        = STAT_PROGRESS;
						end
					end else if (trk_count[hit] != p.switches) begin
						trk_count[hit] = p.switches;
						v.status       = STAT_PROGRESS;
					end else if (budget_left == 0) begin
						v.status = STAT_HUNG_SILENT;
					end else begin
						budget_left = budget_left - 16'd1;
						v.status    = STAT_HUNG;
						v.panic     = panic_on;
					end
				end
			end
			default: begin
			end
		endcase
		v.warnings = budget_left;
		return v;
	endfunction

	function automatic logic [127:0] random_name(input int len);
		logic [127:0] w;
		for (int k = 0; k < 16; k++)
			w[8*k +: 8] = (k < len) ? 8'($urandom_range(1, 255)) : 8'h00;
		return w;
	endfunction

	function automatic logic [127:0] first_bytes(input logic [127:0] name, input int len);
		logic [127:0] w;
		w = '0;
		for (int k = 0; k < 16; k++)
			if (k < len) w[8*k +: 8] = name[8*k +: 8];
		return w;
	endfunction

	// random junk after the terminating zero byte, half of the time
	function automatic logic [127:0] smudge(input logic [127:0] name);
		logic [127:0] w;
		int           len;
		w   = name;
		len = 16;
		for (int k = 15; k >= 0; k--)
			if (name[8*k +: 8] == 8'h00) len = k;
		if (len < 15 && $urandom_range(1) == 1)
			for (int k = len + 1; k < 16; k++) w[8*k +: 8] = 8'($urandom_range(255));
		return w;
	endfunction

	// offer one item, wait for it to be taken, then record its prediction
	task automatic send_probe(input logic [1:0] cmd, input logic [3:0] slot,
			input logic [127:0] name, input logic frozen, input logic [31:0] count);
		probe_t p;
		p.cmd      = cmd;
		p.slot     = slot;
		p.name     = name;
		p.frozen   = frozen;
		p.switches = count;
		if (!calm && $urandom_range(99) < 6) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(negedge clk);
		end
		s_axis_tuser  <= cmd;
		s_axis_tdata  <= {3'b000, count, frozen, name[127:64], name[63:0], slot};
		s_axis_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		expected_verdicts.push_back(judge_item(p));
		sent_count++;
		@(negedge clk);
	endtask

	task automatic check_task(input logic [127:0] name, input logic frozen,
			input logic [31:0] count);
		send_probe(CMD_CHECK, 4'($urandom_range(15)), smudge(name), frozen, count);
	endtask

	task automatic exclude_name(input logic [3:0] slot, input logic [127:0] name);
		send_probe(CMD_WRITE, slot, smudge(name), 1'($urandom_range(1)), $urandom);
	endtask

	task automatic clear_list();
		send_probe(CMD_CLEAR, 4'($urandom_range(15)),
			{$urandom, $urandom, $urandom, $urandom}, 1'($urandom_range(1)), $urandom);
	endtask

	// stop offering and wait until every predicted result has arrived
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (expected_verdicts.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// register write; only called with the block idle
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] value);
		cfg_index <= idx;
		cfg_data  <= value;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		if (idx == CFG_WARNING_LIMIT) begin
			budget_left = value;
		end else if (idx == CFG_PANIC_ENABLE) begin
			panic_on = value[0];
		end
		cfg_count++;
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	// mostly checks of known names, some list edits, clears and spare commands
	task automatic random_probe();
		int           roll;
		int           ix;
		bit           blank;
		logic [127:0] nm;
		logic [31:0]  cnt;
		roll = $urandom_range(99);
		ix   = $urandom_range(active_pool - 1);
		if (roll < 4) begin
			clear_list();
		end else if (roll < 12) begin
			case ($urandom_range(4))
				0, 1:    nm = first_bytes(pool_name[ix], $urandom_range(1, pool_len[ix]));
				2, 3:    nm = random_name($urandom_range(1, 16));
				default: nm = '0;
			endcase
			exclude_name(($urandom_range(2) != 0) ? 4'($urandom_range(3)) :
				4'($urandom_range(15)), nm);
		end else if (roll < 15) begin
			send_probe(CMD_SPARE, 4'($urandom_range(15)),
				{$urandom, $urandom, $urandom, $urandom}, 1'($urandom_range(1)), $urandom);
		end else begin
			blank = ($urandom_range(19) == 0);
			nm    = blank ? '0 : pool_name[ix];
			roll  = $urandom_range(99);
			if (roll < 50 && !blank) cnt = pool_count[ix];
			else if (roll < 55) cnt = '0;
			else cnt = $urandom;
			check_task(nm, $urandom_range(99) < 8, cnt);
			if (!blank && cnt != 0) pool_count[ix] = cnt;
		end
	endtask

	task automatic run_phase(input logic [15:0] limit, input logic pen, input int n,
			input bit quiet);
		drain();
		write_reg(CFG_WARNING_LIMIT, limit);
		write_reg(CFG_PANIC_ENABLE, {15'd0, pen});
		calm = quiet;
		repeat (n) random_probe();
		calm = 1'b0;
	endtask

	task automatic test_exclusion_list();
		logic [127:0] e0;
		logic [127:0] z;
		e0 = random_name(11);
		z  = random_name(16);
		exclude_name(4'd0, e0);
		check_task(first_bytes(e0, 5), 1'b0, 32'd3);   // prefix of a listed name
		check_task(e0, 1'b0, 32'd3);
		check_task('0, 1'b0, 32'd3);                   // empty name matches any entry
		exclude_name(4'd2, z);                         // beyond the first empty slot
		check_task(z, 1'b0, 32'd9);
		send_probe(CMD_SPARE, 4'hF, '1, 1'b1, '1);
		clear_list();
		check_task(first_bytes(e0, 5), 1'b0, 32'd3);
		check_task('0, 1'b0, 32'd4);                   // stored, slot stays empty
		exclude_name(4'd0, z);
		check_task(z, 1'b0, 32'd9);                    // full-length name match
		clear_list();
	endtask

	task automatic test_hung_detection();
		logic [127:0] a;
		a = pool_name[0];
		check_task(a, 1'b0, 32'd0);
		check_task(a, 1'b1, 32'h1234);
		check_task(a, 1'b0, 32'hFFFF_FFFF);
		check_task(a, 1'b0, 32'hFFFF_FFFF);
		check_task(a, 1'b0, 32'd1);
		check_task(a, 1'b1, 32'd1);
		check_task(a, 1'b0, 32'd1);
		drain();
		write_reg(CFG_PANIC_ENABLE, 16'd0);
		check_task(a, 1'b0, 32'd1);
		drain();
		write_reg(CFG_WARNING_LIMIT, 16'd1);
		check_task(a, 1'b0, 32'd1);
		check_task(a, 1'b0, 32'd1);                    // budget used up
		drain();
		write_reg(CFG_WARNING_LIMIT, 16'd0);
		write_reg(CFG_PANIC_ENABLE, 16'd1);
		check_task(a, 1'b0, 32'd1);
		pool_count[0] = 32'd1;
	endtask

	task automatic test_random_traffic();
		run_phase(16'hFFFF, 1'b1, 90, 1'b1);           // no idling on either side
		run_phase(16'd0, 1'b1, 90, 1'b0);
		run_phase(16'd5, 1'b0, 90, 1'b0);
		run_phase(16'($urandom_range(30)), 1'($urandom_range(1)), 90, 1'b0);
		run_phase(16'd1, 1'b1, 90, 1'b0);
	endtask

	// output held off while items keep coming, then a full pause at the input
	task automatic test_backpressure();
		hold_req = 1'b1;
		repeat (30) random_probe();
		drain();
		hold_req = 1'b0;
		repeat (20) random_probe();
	endtask

	task automatic test_table_full();
		drain();
		write_reg(CFG_WARNING_LIMIT, 16'd20);
		write_reg(CFG_PANIC_ENABLE, 16'd1);
		clear_list();
		repeat (18) check_task(random_name($urandom_range(1, 16)), 1'b0, $urandom | 32'd1);
		check_task(pool_name[0], 1'b0, 32'd77);
		check_task(pool_name[0], 1'b0, 32'd77);
		check_task(random_name(16), 1'b1, 32'd5);
		check_task(random_name(3), 1'b0, 32'd0);
		pool_count[0] = 32'd77;
		active_pool   = POOL;
		run_phase(16'($urandom_range(2, 40)), 1'($urandom_range(1)), 120, 1'b0);
	endtask

	// result receiver: random stalls, or one long hold-off on request
	initial begin : receiver
		bit hold_done;
		hold_done = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req && !hold_done) begin
				m_axis_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_done = 1'b1;
			end else begin
				m_axis_tready <= calm || ($urandom_range(99) >= 6);
			end
		end
	end

	// compare each result with the oldest prediction
	always @(posedge clk) begin
		verdict_t    want;
		logic [2:0]  got_status;
		logic        got_panic;
		logic [15:0] got_warn;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got_status = m_axis_tdata[2:0];
			got_panic  = m_axis_tdata[3];
			got_warn   = m_axis_tdata[19:4];
			if (expected_verdicts.size() == 0) begin
				fault_count++;
				if (fault_count <= 10)
					$display("%0t: result with nothing pending: tdata %h", $realtime, m_axis_tdata);
			end else begin
				want = expected_verdicts.pop_front();
				status_seen[want.status]++;
				if (got_status != want.status || got_panic != want.panic ||
						got_warn != want.warnings) begin
					fault_count++;
					if (fault_count <= 10)
						$display("%0t: mismatch status %0d/%0d panic %0d/%0d warnings %0d/%0d %s",
							$realtime, want.status, got_status, want.panic, got_panic,
							want.warnings, got_warn, "(expected/actual)");
				end
			end
		end
	end

	// ends the run when nothing moves for too long
	initial begin : watchdog
		int quiet_cycles;
		quiet_cycles = 0;
		while (quiet_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
					(cfg_valid && cfg_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("watchdog: no item moved for %0d cycles", STALL_LIMIT);
		$display("testbench: done, errors");
		$finish;
	end

	initial begin
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = '0;
		m_axis_tready = 1'b0;
		cfg_valid     = 1'b0;
		cfg_index     = '0;
		cfg_data      = '0;
		calm          = 1'b0;
		hold_req      = 1'b0;
		fault_count   = 0;
		sent_count    = 0;
		cfg_count     = 0;
		active_pool   = BASE_POOL;
		for (int i = 0; i < 8; i++) status_seen[i] = 0;
		// state after reset
		for (int i = 0; i < ENTRIES; i++) begin
			excl_name[i] = '0;
			trk_name[i]  = '0;
			trk_count[i] = '0;
		end
		budget_left = DEFAULT_WARNINGS;
		panic_on    = 1'b1;
		for (int i = 0; i < POOL; i++) begin
			pool_len[i]   = $urandom_range(1, 16);
			pool_name[i]  = random_name(pool_len[i]);
			pool_count[i] = $urandom;
		end

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_exclusion_list();
		test_hung_detection();
		test_random_traffic();
		test_backpressure();
		test_table_full();
		drain();

		if (expected_verdicts.size() != 0) begin
			fault_count += expected_verdicts.size();
			$display("%0d predicted results never arrived", expected_verdicts.size());
		end
		$display("covered %0d items, %0d register writes: %0d done, %0d excluded, %0d skipped",
			sent_count, cfg_count, status_seen[STAT_DONE], status_seen[STAT_EXCLUDED],
			status_seen[STAT_SKIPPED]);
		$display("  %0d progressing, %0d hung reported, %0d hung silent, %0d table full",
			status_seen[STAT_PROGRESS], status_seen[STAT_HUNG],
			status_seen[STAT_HUNG_SILENT], status_seen[STAT_FULL]);
		if (fault_count == 0)
			$display("testbench: done, clean");
		else
			$display("testbench: done, errors");
		$finish;
	end

endmodule

// File: files.f
rtl/core/stdt_pkg.sv
rtl/core/stdt_ram.sv
rtl/core/stdt_cmp.sv
rtl/core/stalled_task_detector_table.sv
rtl/core/stdt_chk.sv
bench/testbench.sv
